>>> design/gss_pkg.sv
// Shared types and constants for the generational slot scheduler.
package gss_pkg;

    localparam int SlotW   = 5;
    localparam int HGenW   = 16;
    localparam int CbW     = 32;
    localparam int TickW   = 64;
    localparam int MaxInv  = 32;
    localparam int InvCntW = 6;
    localparam int SDataW  = 120;
    localparam int MDataW  = 128;

    typedef enum logic [2:0] {
        REQ_SPAWN      = 3'd0,
        REQ_RELEASE    = 3'd1,
        REQ_SET_CAMERA = 3'd2,
        REQ_SET_PLAYER = 3'd3,
        REQ_TICK       = 3'd4,
        REQ_CLEAR      = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_OWNED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_CLOSE,
        S_REPLY
    } state_t;

    // Commands from the sequencer to the slot memory.
    typedef struct packed {
        logic wr;       // write generation and callback at the slot address
        logic drop_cb;  // callback of the slot reads as zero from now on
        logic wipe;     // every entry reads as zero from now on
    } mem_cmd_t;

endpackage

>>> design/gss_slot_mem.sv
// Generation and callback storage per slot, with valid bits standing in for reset.
module gss_slot_mem #(
    parameter int SLOTS    = 32,
    parameter int GEN_BITS = 16,
    parameter int IDX_W    = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gss_pkg::mem_cmd_t       cmd,
    input  logic [IDX_W-1:0]        addr,
    input  logic [GEN_BITS-1:0]     wr_gen,
    input  logic [gss_pkg::CbW-1:0] wr_cb,
    output logic [GEN_BITS-1:0]     rd_gen,
    output logic [gss_pkg::CbW-1:0] rd_cb
);
    import gss_pkg::*;

    logic [GEN_BITS-1:0] gen_mem [SLOTS];
    logic [CbW-1:0]      cb_mem  [SLOTS];

    logic [SLOTS-1:0]    gen_vld_reg;
    logic [SLOTS-1:0]    cb_vld_reg;
    logic [GEN_BITS-1:0] gen_q_reg;
    logic [CbW-1:0]      cb_q_reg;
    logic                gen_qv_reg;
    logic                cb_qv_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            gen_mem[addr] <= wr_gen;
            cb_mem[addr]  <= wr_cb;
        end
        gen_q_reg <= gen_mem[addr];
        cb_q_reg  <= cb_mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_vld_reg <= '0;
            cb_vld_reg  <= '0;
            gen_qv_reg  <= 1'b0;
            cb_qv_reg   <= 1'b0;
        end else begin
            gen_qv_reg <= gen_vld_reg[addr];
            cb_qv_reg  <= cb_vld_reg[addr];
            if (cmd.wipe) begin
                gen_vld_reg <= '0;
                cb_vld_reg  <= '0;
            end else if (cmd.wr) begin
                gen_vld_reg[addr] <= 1'b1;
                cb_vld_reg[addr]  <= 1'b1;
            end else if (cmd.drop_cb) begin
                cb_vld_reg[addr] <= 1'b0;
            end
        end
    end

    assign rd_gen = gen_qv_reg ? gen_q_reg : '0;
    assign rd_cb  = cb_qv_reg ? cb_q_reg : '0;

endmodule

>>> design/gss_slot_alu.sv
// Shared generation unit: bump with zero skip and handle ownership compare.
module gss_slot_alu #(
    parameter int GEN_BITS = 16
) (
    input  logic [GEN_BITS-1:0]       cur_gen,
    input  logic [gss_pkg::HGenW-1:0] handle_gen,
    output logic [GEN_BITS-1:0]       bump_gen,
    output logic [gss_pkg::HGenW-1:0] bump_gen16,
    output logic [gss_pkg::HGenW-1:0] cur_gen16,
    output logic                      gen_match
);
    import gss_pkg::*;

    localparam int CmpW = (GEN_BITS > HGenW) ? GEN_BITS : HGenW;

    logic [GEN_BITS-1:0] inc;

    assign inc        = cur_gen + GEN_BITS'(1);
    // skip generation zero, it marks an invalid handle
    assign bump_gen   = (inc == '0) ? GEN_BITS'(1) : inc;
    assign bump_gen16 = HGenW'(bump_gen);
    assign cur_gen16  = HGenW'(cur_gen);
    assign gen_match  = (handle_gen != '0) && (CmpW'(cur_gen) == CmpW'(handle_gen));

endmodule

>>> design/generational_slot_scheduler_top.sv
// Generational slot scheduler: a slot table under a per-slot sequencer.
// Each request is taken in S_IDLE and then walked slot by slot, each slot step being S_READ
// (read the slot memory) then S_EXEC (act through the shared generation unit). A release or
// flag set walks the handle's slot, a spawn every slot up to the first free one (all SLOTS when
// the table is full), a tick every slot and then a closing beat; a clear, an unknown
// request or a handle slot beyond the table walks no slot; every slot step and every reply or
// closing beat waits while the output register is held. Input is not ready during reset.
// The single-port slot memory and its registered read set the read-then-act slot step.
module generational_slot_scheduler_top #(
    parameter int SLOTS    = 32,
    parameter int GEN_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // slot_index, handle_generation, callback_id, flag_value, tick_number, 2'b0
    input  logic [gss_pkg::SDataW-1:0] s_tdata,
    // req_type
    input  logic [2:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, out_slot, out_generation, out_callback, out_player, out_camera,
    // out_tick, 7'b0
    output logic [gss_pkg::MDataW-1:0] m_tdata,
    // is_invocation
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import gss_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [InvCntW-1:0]   inv_cnt_reg, inv_cnt_next;
    req_t                 req_reg, req_next;
    status_t              stat_reg, stat_next;
    logic [HGenW-1:0]     hgen_reg, hgen_next;
    logic [CbW-1:0]       cb_reg, cb_next;
    logic                 flag_reg, flag_next;
    logic [TickW-1:0]     tick_reg, tick_next;

    logic [SLOTS-1:0]     act_reg, act_next;
    logic [SLOTS-1:0]     ps_reg, ps_next;
    logic [SLOTS-1:0]     pr_reg, pr_next;
    logic [SLOTS-1:0]     cam_reg, cam_next;
    logic [SLOTS-1:0]     pl_reg, pl_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              o_stat_reg, o_stat_next;
    logic                 o_inv_reg, o_inv_next;
    logic [SlotW-1:0]     o_slot_reg, o_slot_next;
    logic [HGenW-1:0]     o_gen_reg, o_gen_next;
    logic [CbW-1:0]       o_cb_reg, o_cb_next;
    logic                 o_pl_reg, o_pl_next;
    logic                 o_cam_reg, o_cam_next;
    logic [TickW-1:0]     o_tick_reg, o_tick_next;
    logic                 o_last_reg, o_last_next;

    mem_cmd_t             mem_cmd;
    logic [GEN_BITS-1:0]  rd_gen, bump_gen;
    logic [CbW-1:0]       rd_cb;
    logic [HGenW-1:0]     bump_gen16, cur_gen16;
    logic                 gen_match;

    logic                 in_acc, out_free, last_slot;
    logic                 a_now, p_now, na, ncam, npl;
    logic [SlotW-1:0]     in_slot;

    assign s_tready  = (state_reg == S_IDLE) && aresetn;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign last_slot = (idx_reg == IDX_W'(SLOTS - 1));
    assign in_slot   = s_tdata[4:0];

    gss_slot_mem #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mem_cmd),
        .addr    (idx_reg),
        .wr_gen  (bump_gen),
        .wr_cb   (cb_reg),
        .rd_gen  (rd_gen),
        .rd_cb   (rd_cb)
    );

    gss_slot_alu #(
        .GEN_BITS (GEN_BITS)
    ) u_alu (
        .cur_gen    (rd_gen),
        .handle_gen (hgen_reg),
        .bump_gen   (bump_gen),
        .bump_gen16 (bump_gen16),
        .cur_gen16  (cur_gen16),
        .gen_match  (gen_match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            act_reg     <= '0;
            ps_reg      <= '0;
            pr_reg      <= '0;
            cam_reg     <= '0;
            pl_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            act_reg     <= act_next;
            ps_reg      <= ps_next;
            pr_reg      <= pr_next;
            cam_reg     <= cam_next;
            pl_reg      <= pl_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        inv_cnt_reg <= inv_cnt_next;
        req_reg     <= req_next;
        stat_reg    <= stat_next;
        hgen_reg    <= hgen_next;
        cb_reg      <= cb_next;
        flag_reg    <= flag_next;
        tick_reg    <= tick_next;
        o_stat_reg  <= o_stat_next;
        o_inv_reg   <= o_inv_next;
        o_slot_reg  <= o_slot_next;
        o_gen_reg   <= o_gen_next;
        o_cb_reg    <= o_cb_next;
        o_pl_reg    <= o_pl_next;
        o_cam_reg   <= o_cam_next;
        o_tick_reg  <= o_tick_next;
        o_last_reg  <= o_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        inv_cnt_next = inv_cnt_reg;
        req_next     = req_reg;
        stat_next    = stat_reg;
        hgen_next    = hgen_reg;
        cb_next      = cb_reg;
        flag_next    = flag_reg;
        tick_next    = tick_reg;
        act_next     = act_reg;
        ps_next      = ps_reg;
        pr_next      = pr_reg;
        cam_next     = cam_reg;
        pl_next      = pl_reg;
        mem_cmd      = '0;

        m_valid_next = m_valid_reg && !m_tready;
        o_stat_next  = o_stat_reg;
        o_inv_next   = o_inv_reg;
        o_slot_next  = o_slot_reg;
        o_gen_next   = o_gen_reg;
        o_cb_next    = o_cb_reg;
        o_pl_next    = o_pl_reg;
        o_cam_next   = o_cam_reg;
        o_tick_next  = o_tick_reg;
        o_last_next  = o_last_reg;

        // slot state as it stands once the tick has committed the marks
        a_now = act_reg[idx_reg] || ps_reg[idx_reg];
        p_now = pr_reg[idx_reg];
        na    = a_now && !p_now;
        ncam  = cam_reg[idx_reg] && !p_now;
        npl   = pl_reg[idx_reg] && !p_now;

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    req_next     = req_t'(s_tuser);
                    hgen_next    = s_tdata[20:5];
                    cb_next      = s_tdata[52:21];
                    flag_next    = s_tdata[53];
                    tick_next    = s_tdata[117:54];
                    idx_next     = '0;
                    inv_cnt_next = '0;
                    stat_next    = ST_OK;
                    case (s_tuser)
                        REQ_SPAWN, REQ_TICK: begin
                            state_next = S_READ;
                        end
                        REQ_RELEASE, REQ_SET_CAMERA, REQ_SET_PLAYER: begin
                            if (32'(in_slot) < 32'(SLOTS)) begin
                                idx_next   = IDX_W'(in_slot);
                                state_next = S_READ;
                            end else begin
                                stat_next  = ST_NOT_OWNED;
                                state_next = S_REPLY;
                            end
                        end
                        default: begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end

            S_READ: begin
                state_next = S_EXEC;
            end

            S_EXEC: begin
                if (out_free) begin
                    o_stat_next = ST_OK;
                    o_inv_next  = 1'b0;
                    o_slot_next = '0;
                    o_gen_next  = '0;
                    o_cb_next   = '0;
                    o_pl_next   = 1'b0;
                    o_cam_next  = 1'b0;
                    o_tick_next = '0;
                    o_last_next = 1'b1;
                    case (req_reg)
                        REQ_SPAWN: begin
                            if (!a_now) begin
                                mem_cmd.wr       = 1'b1;
                                ps_next[idx_reg] = 1'b1;
                                pr_next[idx_reg] = 1'b0;
                                cam_next[idx_reg] = 1'b1;
                                pl_next[idx_reg] = flag_reg;
                                o_slot_next      = SlotW'(idx_reg);
                                o_gen_next       = bump_gen16;
                                m_valid_next     = 1'b1;
                                state_next       = S_IDLE;
                            end else if (last_slot) begin
                                o_stat_next  = ST_FULL;
                                m_valid_next = 1'b1;
                                state_next   = S_IDLE;
                            end else begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = S_READ;
                            end
                        end
                        REQ_TICK: begin
                            act_next[idx_reg] = na;
                            ps_next[idx_reg]  = 1'b0;
                            pr_next[idx_reg]  = 1'b0;
                            cam_next[idx_reg] = ncam;
                            pl_next[idx_reg]  = npl;
                            mem_cmd.drop_cb   = p_now;
                            if (na && (ncam || npl) && (inv_cnt_reg < InvCntW'(MaxInv))) begin
                                o_inv_next   = 1'b1;
                                o_slot_next  = SlotW'(idx_reg);
                                o_gen_next   = cur_gen16;
                                o_cb_next    = rd_cb;
                                o_pl_next    = npl;
                                o_cam_next   = ncam;
                                o_tick_next  = tick_reg;
                                o_last_next  = 1'b0;
                                m_valid_next = 1'b1;
                                inv_cnt_next = inv_cnt_reg + InvCntW'(1);
                            end
                            if (last_slot) begin
                                state_next = S_CLOSE;
                            end else begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            // release or flag set on a handle that must own its slot
                            if (gen_match && a_now) begin
                                case (req_reg)
                                    REQ_RELEASE:    pr_next[idx_reg]  = 1'b1;
                                    REQ_SET_CAMERA: cam_next[idx_reg] = flag_reg;
                                    default:        pl_next[idx_reg]  = flag_reg;
                                endcase
                            end else begin
                                o_stat_next = ST_NOT_OWNED;
                            end
                            m_valid_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                    endcase
                end
            end

            S_CLOSE: begin
                if (out_free) begin
                    o_stat_next  = ST_OK;
                    o_inv_next   = 1'b0;
                    o_slot_next  = '0;
                    o_gen_next   = '0;
                    o_cb_next    = '0;
                    o_pl_next    = 1'b0;
                    o_cam_next   = 1'b0;
                    o_tick_next  = tick_reg;
                    o_last_next  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    if (req_reg == REQ_CLEAR) begin
                        act_next     = '0;
                        ps_next      = '0;
                        pr_next      = '0;
                        cam_next     = '0;
                        pl_next      = '0;
                        mem_cmd.wipe = 1'b1;
                    end
                    o_stat_next  = stat_reg;
                    o_inv_next   = 1'b0;
                    o_slot_next  = '0;
                    o_gen_next   = '0;
                    o_cb_next    = '0;
                    o_pl_next    = 1'b0;
                    o_cam_next   = 1'b0;
                    o_tick_next  = '0;
                    o_last_next  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_inv_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {7'b0, o_tick_reg, o_cam_reg, o_pl_reg, o_cb_reg, o_gen_reg,
                       o_slot_reg, o_stat_reg};

endmodule

>>> design/gss_checker.sv
// Port-level checks for the generational slot scheduler, bound to the top level.
module gss_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [gss_pkg::MDataW-1:0] m_tdata,
    input logic                       m_tuser,
    input logic                       m_tlast
);
    import gss_pkg::*;

    // one request at a time: input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after accepting a beat");

    // invocation beats are never the closing beat and always report ok
    a_inv_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (!m_tlast && (m_tdata[1:0] == ST_OK)))
        else $error("invocation beat marked last or with bad status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code on output");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind generational_slot_scheduler_top gss_checker u_gss_checker (.*);
